>>> hw/rtl/tpg_pkg.sv
// Shared types, constants and coefficient tables for the three-pole Gaussian filter.
`timescale 1ns / 1ps

package tpg_pkg;

  localparam int SampleWidthDefault  = 32;
  localparam int CoefFracBitsDefault = 20;
  localparam int TableDepth          = 20;
  localparam int HalfPeriodW         = 5;
  localparam int RowW                = $clog2(TableDepth);
  localparam int NumTaps             = 4;
  localparam int StepW               = 2;

  // Which coefficient / operand pair the shared multiplier works on
  localparam logic [StepW-1:0] STEP_B0 = 2'd0;
  localparam logic [StepW-1:0] STEP_A1 = 2'd1;
  localparam logic [StepW-1:0] STEP_A2 = 2'd2;
  localparam logic [StepW-1:0] STEP_A3 = 2'd3;

  // Raw coefficients in units of 1e-6, one row per half period
  localparam int RomB0 [TableDepth] = '{
    836701, 718670, 558792, 422292, 318295, 242068, 186612, 146016, 115940, 93340,
    76111, 62791, 52354, 44075, 37432, 32045, 27635, 23991, 20956, 18409};
  localparam int RomA1 [TableDepth] = '{
    173094, 312814, 529009, 749259, 951680, 1130321, 1285644, 1420251, 1537154,
    1639147, 1728632, 1807607, 1877714, 1940297, 1996460, 2047111, 2093000,
    2134754, 2172895, 2207865};
  localparam int RomA2 [TableDepth] = '{
    -9987, -32617, -93283, -187130, -301899, -425875, -550960, -672371, -787614,
    -895601, -996056, -1089148, -1175270, -1254918, -1328618, -1396887, -1460217,
    -1519058, -1573824, -1624889};
  localparam int RomA3 [TableDepth] = '{
    192, 1134, 5483, 15579, 31923, 53486, 78704, 106104, 134520, 163114, 191313,
    218750, 245202, 270546, 294726, 317731, 339582, 360313, 379973, 398615};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_SUM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             load;   // capture sample and coefficient row, seed accumulator
    logic             mult;   // register one product
    logic             accum;  // add the registered product into the accumulator
    logic             emit;   // saturate, write output register, shift history
    logic [StepW-1:0] step;
  } cmd_t;

  function automatic longint raw_coef(int row, int tap);
    longint val;
    val = 0;
    case (tap)
      0:       val = longint'(RomB0[row]);
      1:       val = longint'(RomA1[row]);
      2:       val = longint'(RomA2[row]);
      3:       val = longint'(RomA3[row]);
      default: val = 0;
    endcase
    return val;
  endfunction

endpackage

>>> hw/rtl/three_pole_gaussian_iir_filter_core.sv
// Top level of the three-pole recursive Gaussian smoothing filter.
`timescale 1ns / 1ps

// Three-pole Gaussian IIR smoother on signed fixed-point samples (Q16.16 by default).
//  Input channel : in_valid_i / in_stall_o with sample_i. A transaction is taken on
//    a rising edge with valid high and stall low.
//  Output channel: out_valid_o / out_stall_i with filtered_o, one result per input.
//  Configuration : cfg_we_i writes cfg_data_i into the half-period register
//    (1..20 = periods 2..40; 0 acts as 1, above 20 acts as 20). Write only while idle.
//  Operation: y = B0*x + A1*y1 + A2*y2 + A3*y3 with normalised Q2.F coefficients,
//    rounded to nearest and saturated; the saturated value is fed back.
//  Timing: one shared multiplier takes the four taps in turn (ST_MULT), ST_SUM folds
//    in the last product, ST_EMIT saturates into the output register. A new sample
//    is taken only after the previous result is emitted; the input is stalled
//    meanwhile. The next input is taken while a result waits.
//  Stall: a held-off result stays in the output register; a finished computation
//    waits in the emit step until the register frees up, holding off the input.
//  Reset: asynchronous, active low. Clears the three past outputs, the handshake
//    state and sets the half period to 1.
module three_pole_gaussian_iir_filter_core #(
  parameter int SampleWidth  = tpg_pkg::SampleWidthDefault,
  parameter int CoefFracBits = tpg_pkg::CoefFracBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [tpg_pkg::HalfPeriodW-1:0] cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [SampleWidth-1:0]          sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [SampleWidth-1:0]          filtered_o
);

  tpg_pkg::cmd_t cmd;

  tpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tpg_datapath #(
    .SampleWidth  (SampleWidth),
    .CoefFracBits (CoefFracBits)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_i),
    .cmd_i      (cmd),
    .filtered_o (filtered_o)
  );

endmodule

>>> hw/rtl/tpg_ctrl.sv
// Sequencer for the filter: input acceptance, multiply steps and output register handshake.
`timescale 1ns / 1ps

module tpg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tpg_pkg::cmd_t cmd_o
);

  tpg_pkg::state_e                state_q, state_d;
  logic [tpg_pkg::StepW-1:0]      step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  logic                           slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != tpg_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpg_pkg::ST_IDLE;
      step_q      <= tpg_pkg::STEP_B0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      tpg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = tpg_pkg::STEP_B0;
          state_d    = tpg_pkg::ST_MULT;
        end
      end
      tpg_pkg::ST_MULT: begin
        cmd_o.mult  = 1'b1;
        cmd_o.accum = (step_q != tpg_pkg::STEP_B0);
        step_d      = step_q + 1'b1;
        if (step_q == tpg_pkg::STEP_A3) begin
          state_d = tpg_pkg::ST_SUM;
        end
      end
      tpg_pkg::ST_SUM: begin
        cmd_o.accum = 1'b1;
        state_d     = tpg_pkg::ST_EMIT;
      end
      tpg_pkg::ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = tpg_pkg::ST_IDLE;
        end
      end
      default: state_d = tpg_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result written over an unconsumed output transaction");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == tpg_pkg::ST_MULT &&
                                     step_q == tpg_pkg::STEP_B0))
    else $error("accepted transaction did not start at the first tap");

  a_last_tap_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpg_pkg::ST_MULT && step_q == tpg_pkg::STEP_A3) |=>
      (state_q == tpg_pkg::ST_SUM))
    else $error("multiply sequence did not end after the last tap");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted result not presented");
`endif

endmodule

>>> hw/rtl/tpg_datapath.sv
// Filter datapath: coefficient table, shared multiplier, accumulator, saturation, history.
`timescale 1ns / 1ps

module tpg_datapath #(
  parameter int SampleWidth  = tpg_pkg::SampleWidthDefault,
  parameter int CoefFracBits = tpg_pkg::CoefFracBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [tpg_pkg::HalfPeriodW-1:0] cfg_data_i,
  input  logic signed [SampleWidth-1:0]        sample_i,
  input  tpg_pkg::cmd_t                        cmd_i,
  output logic signed [SampleWidth-1:0]        filtered_o
);

  localparam int CoefW = CoefFracBits + 3;           // signed Q2.F
  localparam int ProdW = SampleWidth + CoefW;
  localparam int AccW  = ProdW + 2;                  // four products plus rounding
  localparam int ShW   = AccW - CoefFracBits;
  localparam logic [tpg_pkg::HalfPeriodW-1:0] LastHp =
    tpg_pkg::HalfPeriodW'(tpg_pkg::TableDepth);
  localparam logic signed [AccW-1:0] RoundInit = AccW'(1) <<< (CoefFracBits - 1);
  localparam logic signed [SampleWidth-1:0] SatMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] SatMin = {1'b1, {(SampleWidth-1){1'b0}}};

  // Normalised coefficient table, each row divided by its own sum
  logic signed [CoefW-1:0] coef_rom [tpg_pkg::TableDepth][tpg_pkg::NumTaps];

  for (genvar g = 0; g < tpg_pkg::TableDepth; g++) begin : g_row
    localparam longint RawSum = tpg_pkg::raw_coef(g, 0) + tpg_pkg::raw_coef(g, 1) +
                                tpg_pkg::raw_coef(g, 2) + tpg_pkg::raw_coef(g, 3);
    localparam longint RowSum = (RawSum < 1) ? 1 : RawSum;
    for (genvar k = 0; k < tpg_pkg::NumTaps; k++) begin : g_tap
      localparam longint Raw = tpg_pkg::raw_coef(g, k);
      localparam longint Mag = (Raw < 0) ? -Raw : Raw;
      localparam longint Q   = ((Mag <<< CoefFracBits) + RowSum / 2) / RowSum;
      localparam longint Val = (Raw < 0) ? -Q : Q;
      assign coef_rom[g][k] = CoefW'(Val);
    end
  end

  logic [tpg_pkg::HalfPeriodW-1:0] half_period_q;
  logic [tpg_pkg::RowW-1:0]        row;
  logic signed [CoefW-1:0]         coef_q [tpg_pkg::NumTaps];
  logic signed [SampleWidth-1:0]   sample_q;
  logic signed [SampleWidth-1:0]   hist_q [3];
  logic signed [CoefW-1:0]         mult_a;
  logic signed [SampleWidth-1:0]   mult_b;
  logic signed [ProdW-1:0]         product_d, product_q;
  logic signed [AccW-1:0]          acc_q, acc_d;
  logic signed [ShW-1:0]           shifted;
  logic signed [SampleWidth-1:0]   sat;
  logic signed [SampleWidth-1:0]   filtered_q;

  // Out-of-range half periods clamp to the ends of the table
  always_comb begin
    if (half_period_q == '0) begin
      row = '0;
    end else if (half_period_q > LastHp) begin
      row = tpg_pkg::RowW'(tpg_pkg::TableDepth - 1);
    end else begin
      row = tpg_pkg::RowW'(half_period_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= tpg_pkg::HalfPeriodW'(1);
    end else if (cfg_we_i) begin
      half_period_q <= cfg_data_i;
    end
  end

  always_comb begin
    mult_a = coef_q[cmd_i.step];
    unique case (cmd_i.step)
      tpg_pkg::STEP_B0: mult_b = sample_q;
      tpg_pkg::STEP_A1: mult_b = hist_q[0];
      tpg_pkg::STEP_A2: mult_b = hist_q[1];
      tpg_pkg::STEP_A3: mult_b = hist_q[2];
      default:          mult_b = sample_q;
    endcase
  end

  assign product_d = mult_a * mult_b;
  assign acc_d     = acc_q + AccW'(product_q);

  // Round already seeded; drop fraction bits and clamp to the sample range
  assign shifted = ShW'(acc_q >>> CoefFracBits);
  always_comb begin
    if (&shifted[ShW-1:SampleWidth-1] || ~|shifted[ShW-1:SampleWidth-1]) begin
      sat = shifted[SampleWidth-1:0];
    end else if (shifted[ShW-1]) begin
      sat = SatMin;
    end else begin
      sat = SatMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
      for (int k = 0; k < tpg_pkg::NumTaps; k++) begin
        coef_q[k] <= coef_rom[row][k];
      end
    end
    if (cmd_i.mult) begin
      product_q <= product_d;
    end
    if (cmd_i.load) begin
      acc_q <= RoundInit;
    end else if (cmd_i.accum) begin
      acc_q <= acc_d;
    end
    if (cmd_i.emit) begin
      filtered_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
      hist_q[2] <= '0;
    end else if (cmd_i.emit) begin
      hist_q[0] <= sat;
      hist_q[1] <= hist_q[0];
      hist_q[2] <= hist_q[1];
    end
  end

  assign filtered_o = filtered_q;

endmodule
